[rtl/assert_macros.svh]
// Assertion macros used by the top level of the source rewrite block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/vksr_pkg.sv]
// Types, constants and a checksum helper for the VLAN-keyed IPv4 source rewrite.
package vksr_pkg;

	// Register map: one 32-bit word per register
	localparam int unsigned PADDR_W = 5;
	localparam logic [2:0] REG_MODE          = 3'd0;
	localparam logic [2:0] REG_GROUP_LOW     = 3'd1;
	localparam logic [2:0] REG_GROUP_HIGH    = 3'd2;
	localparam logic [2:0] REG_INSIDE_PREFIX = 3'd3;
	localparam logic [2:0] REG_OUTSIDE_OCTET = 3'd4;

	// Mode codes
	localparam logic [1:0] MODE_OUTWARD = 2'd0;
	localparam logic [1:0] MODE_INWARD  = 2'd1;

	// Register reset values
	localparam logic [1:0]  MODE_RST          = MODE_OUTWARD;
	localparam logic [7:0]  GROUP_LOW_RST     = 8'd1;
	localparam logic [7:0]  GROUP_HIGH_RST    = 8'd16;
	localparam logic [15:0] INSIDE_PREFIX_RST = 16'hC0A8;
	localparam logic [7:0]  OUTSIDE_OCTET_RST = 8'd10;

	// Protocol numbers
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [15:0] IP_HDR_BYTES = 16'd20;

	// Group = TCI / 100 as (TCI * 83887) >> 23, exact for every 16-bit TCI
	localparam logic [16:0] GROUP_RECIP = 17'd83887;
	localparam int unsigned GROUP_SHIFT = 23;
	localparam int unsigned GROUP_W     = 10;

	typedef struct packed {
		logic        has_tag;
		logic [15:0] tag_control;
		logic [15:0] version_tos;
		logic [15:0] total_length;
		logic [15:0] ident;
		logic [15:0] frag_word;
		logic [7:0]  ttl;
		logic [7:0]  protocol;
		logic [31:0] orig_source;
		logic [31:0] dst_addr;
		logic [15:0] l4_sum;
		logic        last_in_batch;
	} hdr_beat_t;

	typedef struct packed {
		logic        pass;
		logic [31:0] new_source;
		logic [15:0] ip_checksum;
		logic [15:0] l4_checksum;
		logic        l4_checksum_write;
		logic        batch_last;
	} res_beat_t;

	// Fold a sum of up to sixteen 16-bit words into 16 bits, ones' complement
	function automatic logic [15:0] csum_fold(input logic [19:0] s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

[rtl/vlan_keyed_ipv4_source_rewrite.sv]
// Top level of the VLAN-keyed IPv4 source rewrite with checksum recompute.
// Each accepted header beat passes the input register, then the result register.
// Throughput: one header beat per cycle while res_stall is low; the input register
// feeds the result register via the group multiplier and two checksum adder trees.
// Reset clears both stage valid bits and loads the register defaults
// (mode outward, groups 1 to 16, prefix 192.168, outside octet 10).
module vlan_keyed_ipv4_source_rewrite
	import vksr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Header channel
	input  logic                hdr_valid,
	output logic                hdr_stall,
	input  hdr_beat_t           hdr,
	// Result channel
	output logic                res_valid,
	input  logic                res_stall,
	output res_beat_t           res,
	// Configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [1:0]  mode_q;
	logic [7:0]  group_low_q;
	logic [7:0]  group_high_q;
	logic [15:0] inside_prefix_q;
	logic [7:0]  outside_octet_q;
	logic [2:0]  reg_idx;
	logic        cfg_wr;

	logic        valid_s1;
	hdr_beat_t   hdr_s1;
	logic        valid_s2;
	res_beat_t   res_s2;
	logic        adv_s2;
	logic        move_s1;
	logic        load_s1;

	logic [32:0]        group_prod;
	logic [GROUP_W-1:0] group;
	logic               outward_ok;
	logic               keep;
	logic               is_icmp;
	logic [31:0]        nsrc;
	logic [31:0]        out_src;
	logic [15:0]        l4_len;
	logic [19:0]        ip_sum;
	logic [19:0]        l4_sum_w;
	logic [15:0]        ip_ck;
	logic [15:0]        l4_ck;
	logic               l4_wr;
	res_beat_t          res_d;
	logic               res_drop_clean;
	logic               res_l4_sane;

	// Register access decode
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_RST;
			group_low_q     <= GROUP_LOW_RST;
			group_high_q    <= GROUP_HIGH_RST;
			inside_prefix_q <= INSIDE_PREFIX_RST;
			outside_octet_q <= OUTSIDE_OCTET_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MODE:          mode_q          <= pwdata[1:0];
				REG_GROUP_LOW:     group_low_q     <= pwdata[7:0];
				REG_GROUP_HIGH:    group_high_q    <= pwdata[7:0];
				REG_INSIDE_PREFIX: inside_prefix_q <= pwdata[15:0];
				REG_OUTSIDE_OCTET: outside_octet_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_MODE:          prdata = {30'd0, mode_q};
			REG_GROUP_LOW:     prdata = {24'd0, group_low_q};
			REG_GROUP_HIGH:    prdata = {24'd0, group_high_q};
			REG_INSIDE_PREFIX: prdata = {16'd0, inside_prefix_q};
			REG_OUTSIDE_OCTET: prdata = {24'd0, outside_octet_q};
			default:           prdata = 32'd0;
		endcase
	end

	// Pipeline flow: the result register drains, the input register refills
	assign adv_s2    = !valid_s2 || !res_stall;
	assign move_s1   = valid_s1 && adv_s2;
	assign load_s1   = !valid_s1 || move_s1;
	assign hdr_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= hdr_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (load_s1 && hdr_valid) begin
			hdr_s1 <= hdr;
		end
		if (move_s1) begin
			res_s2 <= res_d;
		end
	end

	// Group number from the whole TCI
	assign group_prod = {17'd0, hdr_s1.tag_control} * {16'd0, GROUP_RECIP};
	assign group      = group_prod[GROUP_SHIFT +: GROUP_W];

	// Qualify the packet for outward rewrite
	assign is_icmp    = hdr_s1.protocol == PROTO_ICMP;
	assign outward_ok = hdr_s1.has_tag
		&& group >= {2'd0, group_low_q}
		&& group <= {2'd0, group_high_q}
		&& hdr_s1.orig_source[31:16] == inside_prefix_q
		&& (is_icmp || hdr_s1.protocol == PROTO_TCP || hdr_s1.protocol == PROTO_UDP);

	assign nsrc = {outside_octet_q, group[7:0], hdr_s1.orig_source[15:0]};

	// Verdict per mode
	always_comb begin
		case (mode_q)
			MODE_OUTWARD: begin
				keep    = outward_ok;
				out_src = outward_ok ? nsrc : hdr_s1.orig_source;
				l4_wr   = outward_ok && !is_icmp;
			end
			MODE_INWARD: begin
				keep    = 1'b1;
				out_src = hdr_s1.orig_source;
				l4_wr   = 1'b0;
			end
			default: begin
				keep    = 1'b0;
				out_src = hdr_s1.orig_source;
				l4_wr   = 1'b0;
			end
		endcase
	end

	// Header checksum over the fixed 20-byte header
	assign ip_sum = {4'd0, hdr_s1.version_tos} + {4'd0, hdr_s1.total_length}
		+ {4'd0, hdr_s1.ident} + {4'd0, hdr_s1.frag_word}
		+ {4'd0, hdr_s1.ttl, hdr_s1.protocol}
		+ {4'd0, out_src[31:16]} + {4'd0, out_src[15:0]}
		+ {4'd0, hdr_s1.dst_addr[31:16]} + {4'd0, hdr_s1.dst_addr[15:0]};
	assign ip_ck  = ~csum_fold(ip_sum);

	// L4 checksum with pseudo header; zero goes out as all ones
	assign l4_len   = hdr_s1.total_length - IP_HDR_BYTES;
	assign l4_sum_w = {4'd0, out_src[31:16]} + {4'd0, out_src[15:0]}
		+ {4'd0, hdr_s1.dst_addr[31:16]} + {4'd0, hdr_s1.dst_addr[15:0]}
		+ {12'd0, hdr_s1.protocol} + {4'd0, l4_len} + {4'd0, hdr_s1.l4_sum};
	always_comb begin
		l4_ck = ~csum_fold(l4_sum_w);
		if (l4_ck == 16'd0) begin
			l4_ck = 16'hFFFF;
		end
	end

	// Assemble the result beat
	always_comb begin
		res_d.pass              = keep;
		res_d.new_source        = out_src;
		res_d.ip_checksum       = keep ? ip_ck : 16'd0;
		res_d.l4_checksum       = l4_wr ? l4_ck : 16'd0;
		res_d.l4_checksum_write = l4_wr;
		res_d.batch_last        = hdr_s1.last_in_batch;
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// Result beat properties checked below
	assign res_drop_clean = res.ip_checksum == 16'd0 && res.l4_checksum == 16'd0
		&& !res.l4_checksum_write;
	assign res_l4_sane    = res.pass && res.l4_checksum != 16'd0;

`include "assert_macros.svh"

	`ASSERT_SAME(a_drop_zero, clk, arst_n, res_valid && !res.pass, res_drop_clean)
	`ASSERT_SAME(a_l4_kept, clk, arst_n, res_valid && res.l4_checksum_write, res_l4_sane)
	`ASSERT_SAME(a_stall_full, clk, arst_n, hdr_stall, valid_s1 && valid_s2)
	`ASSERT_NEXT(a_s1_drains, clk, arst_n, valid_s1 && !valid_s2, valid_s2)

endmodule
